// File: hw/rtl/smce_pkg.sv
// Shared types, constants and exp tables for the softmax cross-entropy gradient block.
package smce_pkg;
   localparam int SCORE_W = 32;
   localparam int GRAD_W  = 25;
   localparam int HESS_W  = 23;
   localparam int MAX_CLASSES = 32;
   localparam logic [GRAD_W-1:0] GRAD_MAX = 25'd16777215;
   localparam logic [HESS_W-1:0] HESS_MAX = 23'd8388607;

   localparam logic CSR_NUM_CLASSES = 1'b0;
   localparam logic CSR_UNIT_WEIGHT = 1'b1;

   typedef struct packed {
      logic        start;
      logic [16:0] e;
      logic [21:0] sum;
   } div_req_type;

   function automatic logic [16:0] e0_lut(input logic [3:0] k);
      logic [16:0] v;
      case (k)
         4'd0: v = 17'd65536;  4'd1: v = 17'd24109; 4'd2: v = 17'd8869;
         4'd3: v = 17'd3263;   4'd4: v = 17'd1200;  4'd5: v = 17'd442;
         4'd6: v = 17'd162;    4'd7: v = 17'd60;    4'd8: v = 17'd22;
         4'd9: v = 17'd8;      4'd10: v = 17'd3;    4'd11: v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] e1_lut(input logic [3:0] i);
      logic [16:0] v;
      case (i)
         4'd0: v = 17'd65536; 4'd1: v = 17'd61565; 4'd2: v = 17'd57835;
         4'd3: v = 17'd54331; 4'd4: v = 17'd51039; 4'd5: v = 17'd47947;
         4'd6: v = 17'd45042; 4'd7: v = 17'd42313; 4'd8: v = 17'd39750;
         4'd9: v = 17'd37341; 4'd10: v = 17'd35079; 4'd11: v = 17'd32954;
         4'd12: v = 17'd30957; 4'd13: v = 17'd29081; 4'd14: v = 17'd27319;
         default: v = 17'd25664;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] e2_lut(input logic [3:0] i);
      logic [16:0] v;
      case (i)
         4'd0: v = 17'd65536; 4'd1: v = 17'd65280; 4'd2: v = 17'd65026;
         4'd3: v = 17'd64772; 4'd4: v = 17'd64520; 4'd5: v = 17'd64268;
         4'd6: v = 17'd64018; 4'd7: v = 17'd63768; 4'd8: v = 17'd63520;
         4'd9: v = 17'd63272; 4'd10: v = 17'd63025; 4'd11: v = 17'd62780;
         4'd12: v = 17'd62535; 4'd13: v = 17'd62291; 4'd14: v = 17'd62048;
         default: v = 17'd61806;
      endcase
      return v;
   endfunction
endpackage

// File: hw/rtl/softmax_cross_entropy_gradient.sv
// Top level of the softmax cross-entropy gradient and hessian block.
// Scores enter one per transfer on req_score with start; busy low means a
// transfer is taken. The transfer that completes a row (num_classes scores)
// also carries req_label and req_weight. The block then goes busy: pass one
// reads each stored score and forms exp from a table lookup, two table
// multiplies and a fraction correction on one shared multiplier, skipping the
// table multiplies when the exponent underflows to zero. Pass two divides each
// exp by the sum on a bit-serial divider over a 34-bit numerator and forms the
// hessian on the same multiplier and the gradient on a separate product.
// Each result is shown for one cycle with rsp_valid; the receiver cannot stall.
// A row keeps busy high after its last score until its last result is formed;
// the last result is shown in the first cycle busy is low again.
// Non-final scores are taken back to back. Reset clears the fill count, maximum
// and registers (num_classes 2, unit_weight 1); the score memory is not cleared.
module softmax_cross_entropy_gradient
   import smce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_score,
   input  logic signed [7:0]  req_label,
   input  logic [15:0]        req_weight,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [5:0]         csr_wr_data,
   output logic               rsp_valid,
   output logic signed [24:0] rsp_gradient,
   output logic [22:0]        rsp_hessian,
   output logic [4:0]         rsp_class_index,
   output logic               rsp_last,
   output logic               rsp_label_error
);
   localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CW = $clog2(MAX_CLASSES + 1);

   localparam logic [3:0] S_FILL = 4'd0, S_RD = 4'd1, S_E1 = 4'd2, S_E2 = 4'd3,
      S_E3 = 4'd4, S_E4 = 4'd5, S_DIV = 4'd6, S_DW = 4'd7, S_G = 4'd8,
      S_H1 = 4'd9, S_H2 = 4'd10, S_OUT = 4'd11, S_H3 = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [5:0]  ncls_ff;
   logic        unitw_ff;
   logic [CW-1:0] fill_ff, fill_in, len_ff, len_in, idx_ff, idx_in;
   logic signed [31:0] max_ff, max_in;
   logic [21:0] sum_ff, sum_in;
   logic [16:0] acc_ff, acc_in, p_ff, p_in;
   logic [15:0] frac_ff, frac_in;
   logic [16:0] w_ff, w_in;
   logic [7:0]  lab_ff, lab_in;
   logic        err_ff, err_in;
   logic signed [24:0] g_ff, g_in;
   logic [22:0] h_ff, h_in;
   logic        v_ff, v_in;
   logic [CW-1:0] n_eff;

   // shared multiplier
   logic [33:0] mul_a, mul_b;
   logic [33:0] mul_p;
   assign mul_p = 34'(mul_a * mul_b);

   // exp value store (per class, reused in pass two)
   logic        ewr;
   logic [AW-1:0] raddr, waddr;
   logic [31:0] sdata;
   logic [16:0] edata;
   logic        swr;

   smce_ram #(.WIDTH(32), .DEPTH(MAX_CLASSES)) u_score (
      .clock(clock), .wr_en(swr), .wr_addr(fill_ff[AW-1:0]), .wr_data(req_score),
      .rd_addr(raddr), .rd_data(sdata));
   smce_ram #(.WIDTH(17), .DEPTH(MAX_CLASSES)) u_exp (
      .clock(clock), .wr_en(ewr), .wr_addr(waddr), .wr_data(acc_in),
      .rd_addr(raddr), .rd_data(edata));

   div_req_type dreq;
   logic        ddone;
   logic [16:0] dq;
   smce_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quot(dq));

   logic signed [32:0] dd;
   logic signed [17:0] pa;
   logic signed [34:0] gp;

   always_comb begin
      if (ncls_ff == 6'd0) n_eff = CW'(1);
      else if (32'(ncls_ff) > MAX_CLASSES) n_eff = CW'(MAX_CLASSES);
      else n_eff = CW'(ncls_ff);
   end

   assign busy  = (st_ff != S_FILL);
   assign swr   = start && !busy;
   assign raddr = idx_ff[AW-1:0];
   assign waddr = idx_ff[AW-1:0];
   assign dd    = 33'(max_ff) - 33'(signed'(sdata));
   assign pa    = 18'(p_ff) - ((idx_ff == CW'(lab_ff)) ? 18'sd65536 : 18'sd0);
   assign gp    = 35'(pa) * 35'(signed'({1'b0, w_ff}));

   always_comb begin
      logic [CW:0] cnt;
      logic signed [34:0] gr;
      logic [33:0] hp;
      st_in = st_ff; fill_in = fill_ff; len_in = len_ff; idx_in = idx_ff;
      max_in = max_ff; sum_in = sum_ff; acc_in = acc_ff; p_in = p_ff;
      frac_in = frac_ff; w_in = w_ff; lab_in = lab_ff; err_in = err_ff;
      g_in = g_ff; h_in = h_ff; v_in = 1'b0;
      ewr = 1'b0; dreq = '0; mul_a = '0; mul_b = '0;
      cnt = '0; gr = '0; hp = '0;
      unique case (st_ff)
         S_FILL: if (swr) begin
            if (fill_ff == '0 || req_score > max_ff) max_in = req_score;
            cnt = (CW+1)'(fill_ff) + 1'b1;
            if (cnt < (CW+1)'(n_eff)) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               fill_in = '0;
               len_in  = CW'(cnt);
               err_in  = (req_label < 0) || ((CW+1)'(req_label) >= cnt);
               lab_in  = err_in ? 8'd0 : req_label;
               w_in    = unitw_ff ? 17'd256 : {1'b0, req_weight};
               idx_in  = '0;
               sum_in  = '0;
               st_in   = S_RD;
            end
         end
         S_RD: st_in = S_E1;
         S_E1: begin
            frac_in = dd[15:0];
            if (dd[32:16] >= 17'd12) begin
               acc_in = '0;
               st_in  = S_E4;
               frac_in = '0;
            end else begin
               acc_in = e0_lut(dd[19:16]);
               st_in  = S_E2;
            end
         end
         S_E2: begin
            mul_a  = 34'(acc_ff); mul_b = 34'(e1_lut(frac_ff[15:12]));
            acc_in = 17'((mul_p + 34'd32768) >> 16);
            st_in  = S_E3;
         end
         S_E3: begin
            mul_a  = 34'(acc_ff); mul_b = 34'(e2_lut(frac_ff[11:8]));
            acc_in = 17'((mul_p + 34'd32768) >> 16);
            st_in  = S_E4;
         end
         S_E4: begin
            mul_a  = 34'(acc_ff); mul_b = 34'(frac_ff[7:0]);
            acc_in = acc_ff - 17'((mul_p + 34'd32768) >> 16);
            ewr    = 1'b1;
            sum_in = sum_ff + 22'(acc_in);
            if (idx_ff + 1'b1 == len_ff) begin
               idx_in = '0;
               if (sum_in == '0) sum_in = 22'd1;
               st_in  = S_DIV;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = S_RD;
            end
         end
         S_DIV: st_in = S_DW;
         S_DW: begin
            if (!ddone && !dreq.start) begin
               dreq.start = 1'b1; dreq.e = edata; dreq.sum = sum_ff;
               st_in = S_G;
            end
         end
         S_G: if (ddone) begin
            p_in  = dq;
            st_in = S_H1;
         end
         S_H1: begin
            gr = (gp + 35'sd128) >>> 8;
            g_in = (gr > signed'(35'(GRAD_MAX))) ? signed'(GRAD_MAX) : 25'(gr);
            // q = p(1-p), split into high and low halves
            mul_a = 34'(p_ff); mul_b = 34'(18'd65536 - 18'(p_ff));
            acc_in = 17'(mul_p >> 16);
            frac_in = mul_p[15:0];
            st_in = S_H2;
         end
         S_H2: begin
            mul_a = 34'(frac_ff);
            mul_b = 34'(w_ff);
            h_in  = 23'((mul_p + 34'd4194304) >> 16);
            st_in = S_H3;
         end
         S_H3: begin
            mul_a = 34'(acc_ff);
            mul_b = 34'(w_ff);
            hp = (mul_p + 34'(h_ff)) >> 7;
            if (hp > 34'(HESS_MAX)) h_in = HESS_MAX;
            else if (hp == '0) h_in = 23'd1;
            else h_in = 23'(hp);
            st_in = S_OUT;
         end
         S_OUT: begin
            v_in = 1'b1;
            if (idx_ff + 1'b1 == len_ff) begin
               idx_in = '0;
               st_in  = S_FILL;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = S_DIV;
            end
         end
         default: st_in = S_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_FILL; fill_ff <= '0; max_ff <= '0;
         ncls_ff <= 6'd2; unitw_ff <= 1'b1; v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; fill_ff <= fill_in; max_ff <= max_in; v_ff <= v_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_NUM_CLASSES: ncls_ff <= csr_wr_data;
               CSR_UNIT_WEIGHT: unitw_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
      len_ff <= len_in; idx_ff <= idx_in; sum_ff <= sum_in; acc_ff <= acc_in;
      p_ff <= p_in; frac_ff <= frac_in; w_ff <= w_in; lab_ff <= lab_in;
      err_ff <= err_in; g_ff <= g_in; h_ff <= h_in;
      if (st_ff == S_OUT) begin
         rsp_gradient <= g_ff; rsp_hessian <= h_ff;
         rsp_class_index <= 5'(idx_ff);
         rsp_last <= (idx_ff + 1'b1 == len_ff);
         rsp_label_error <= err_ff;
      end
   end

   assign rsp_valid = v_ff;

   property no_take_when_busy;
      @(posedge clock) disable iff (reset) busy |=> !$changed(fill_ff) || st_ff == S_FILL;
   endproperty
   a_busy: assert property (no_take_when_busy) else $error("fill moved while busy");
   a_hess: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hessian != '0) else $error("hessian zero");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> st_ff == S_FILL) else $error("last without idle");
endmodule

// File: hw/rtl/smce_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module smce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/smce_div.sv
// Restoring divider: quotient of (e << 16) + sum/2 over sum, one bit per cycle.
module smce_div
   import smce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [16:0] quot
);
   localparam int NW = 34;
   logic [NW-1:0] num_ff, num_in;
   logic [22:0]   rem_ff, rem_in;
   logic [21:0]   den_ff, den_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [22:0]   trial;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[21:0], num_ff[NW-1]};
      if (req.start) begin
         num_in  = {req.e, 16'd0} + {12'd0, req.sum[21:1]};
         den_in  = req.sum;
         rem_in  = '0;
         cnt_in  = 6'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = (num_ff > 34'd65536) ? 17'd65536 : num_ff[16:0];
endmodule
